>>> rtl/core/deque_pkg.sv
// Shared types and constants for the double-ended queue.
package deque_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int FUNC_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 9;
   localparam int DROP_W  = 9;
   localparam int OCC_W   = 9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_REAR  = 3'd0,
      FUNC_POP_FRONT  = 3'd1,
      FUNC_PUSH_FRONT = 3'd2,
      FUNC_POP_REAR   = 3'd3,
      FUNC_PEEK       = 3'd4,
      FUNC_DROP_FRONT = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Decode result handed from the control logic to the top level.
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      status_type status;
   } ctrl_flags_type;

endpackage

>>> rtl/core/deque_if.sv
// Request and response channel interfaces of the double-ended queue.
interface deque_req_if;
   logic                                valid;
   logic                                ready;
   logic [deque_pkg::FUNC_W-1:0]        func;
   logic signed [deque_pkg::VALUE_W-1:0] value;
   logic [deque_pkg::POS_W-1:0]         position;
   logic [deque_pkg::DROP_W-1:0]        drop_count;

   modport source (output valid, func, value, position, drop_count, input ready);
   modport sink   (input valid, func, value, position, drop_count, output ready);
endinterface

interface deque_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [deque_pkg::VALUE_W-1:0] result_value;
   logic [1:0]                          status;
   logic [deque_pkg::OCC_W-1:0]         occupancy;

   modport source (output valid, result_value, status, occupancy, input ready);
   modport sink   (input valid, result_value, status, occupancy, output ready);
endinterface

>>> rtl/core/deque_ctrl.sv
// Request decode: next ring pointers, store access and status for one request.
module deque_ctrl #(
   parameter int DEPTH = deque_pkg::DEPTH_DEFAULT,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic [deque_pkg::FUNC_W-1:0] func,
   input  logic [deque_pkg::POS_W-1:0]  position,
   input  logic [deque_pkg::DROP_W-1:0] drop_count,
   input  logic [IW-1:0]                front,
   input  logic [CW-1:0]                count,
   output logic [IW-1:0]                front_in,
   output logic [CW-1:0]                count_in,
   output logic [IW-1:0]                wr_addr,
   output logic [IW-1:0]                rd_addr,
   output deque_pkg::ctrl_flags_type    flags
);

   localparam int SW    = IW + 1;
   localparam int CMP_W = (CW > deque_pkg::POS_W) ? CW : deque_pkg::POS_W;

   // (base + off) mod DEPTH; the sum stays below twice the depth.
   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   logic              full;
   logic              empty;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  drop_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CW-1:0]     drop_n;
   logic              pos_bad;

   assign full     = (count >= CW'(DEPTH));
   assign empty    = (count == '0);
   assign pos_ext  = CMP_W'(position);
   assign drop_ext = CMP_W'(drop_count);
   assign cnt_ext  = CMP_W'(count);
   assign drop_n   = (drop_ext < cnt_ext) ? CW'(drop_ext) : count;
   assign pos_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);

   always_comb begin
      front_in     = front;
      count_in     = count;
      wr_addr      = front;
      rd_addr      = front;
      flags.wr_en  = 1'b0;
      flags.rd_en  = 1'b0;
      flags.status = deque_pkg::STATUS_OK;
      unique case (deque_pkg::func_type'(func))
         deque_pkg::FUNC_PUSH_REAR: begin
            if (full) begin
               flags.status = deque_pkg::STATUS_FULL;
            end else begin
               wr_addr     = ring_add(front, count);
               flags.wr_en = 1'b1;
               count_in    = count + CW'(1);
            end
         end
         deque_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               flags.status = deque_pkg::STATUS_EMPTY;
            end else begin
               rd_addr     = front;
               flags.rd_en = 1'b1;
               front_in    = ring_add(front, CW'(1));
               count_in    = count - CW'(1);
            end
         end
         deque_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               flags.status = deque_pkg::STATUS_FULL;
            end else begin
               front_in    = ring_add(front, CW'(DEPTH - 1));
               wr_addr     = front_in;
               flags.wr_en = 1'b1;
               count_in    = count + CW'(1);
            end
         end
         deque_pkg::FUNC_POP_REAR: begin
            if (empty) begin
               flags.status = deque_pkg::STATUS_EMPTY;
            end else begin
               rd_addr     = ring_add(front, count - CW'(1));
               flags.rd_en = 1'b1;
               count_in    = count - CW'(1);
            end
         end
         deque_pkg::FUNC_PEEK: begin
            if (pos_bad) begin
               flags.status = deque_pkg::STATUS_EMPTY;
            end else begin
               rd_addr     = ring_add(front, CW'(pos_ext - CMP_W'(1)));
               flags.rd_en = 1'b1;
            end
         end
         deque_pkg::FUNC_DROP_FRONT: begin
            front_in = ring_add(front, drop_n);
            count_in = count - drop_n;
         end
         default: begin
            // unused codes leave the queue untouched
         end
      endcase
   end

endmodule

>>> rtl/core/double_ended_queue.sv
// Top level of the double-ended queue: pointers, element store and result register.
//
// Usage:
//   req channel carries one request per item: func selects push rear, pop front,
//   push front, pop rear, peek at a 1-based position, or drop from the front;
//   value is the element to push, position the peek slot, drop_count the drop size.
//   rsp channel returns exactly one response per request, in order: the value
//   popped or peeked (zero otherwise), a status (ok, empty/out of range, full)
//   and the occupancy after the request.
//   Response: valid in the cycle after the request is accepted.
//   Throughput: one request per cycle unless a response stalls. Each request
//   touches at most one store entry, at a ring index computed from the front
//   pointer and count; the store's single read and write ports serve it in that cycle.
//   Stall: while a response waits unaccepted, req_ch.ready is low; it rises
//   again in the cycle rsp_ch.ready takes the waiting response, so a new
//   request can enter in that same cycle.
//   Reset: synchronous, active high; the queue comes up empty with the front
//   pointer at zero and no response pending. The store itself is not cleared:
//   only entries written by earlier pushes can ever be read back.
module double_ended_queue #(
   parameter int DEPTH = deque_pkg::DEPTH_DEFAULT,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic        clock,
   input  logic        reset,
   deque_req_if.sink   req_ch,
   deque_rsp_if.source rsp_ch
);

   // queue pointers
   logic [IW-1:0] front_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] front_in;
   logic [CW-1:0] count_in;

   // response register
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 has_read_ff;
   deque_pkg::status_type                status_ff;
   logic [deque_pkg::OCC_W-1:0]          occ_ff;
   logic signed [deque_pkg::VALUE_W-1:0] rd_data_ff;

   // element store
   logic signed [deque_pkg::VALUE_W-1:0] store_mem [DEPTH];
   logic [IW-1:0]                        wr_addr;
   logic [IW-1:0]                        rd_addr;
   deque_pkg::ctrl_flags_type            flags;

   logic accept;

   // Ready whenever the response slot is free or being drained this cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   deque_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .func       (req_ch.func),
      .position   (req_ch.position),
      .drop_count (req_ch.drop_count),
      .front      (front_ff),
      .count      (count_ff),
      .front_in   (front_in),
      .count_in   (count_in),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .flags      (flags)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   // Response payload loads only on accept, so it holds through a stall.
   always_ff @(posedge clock) begin
      if (accept) begin
         has_read_ff <= flags.rd_en;
         status_ff   <= flags.status;
         occ_ff      <= deque_pkg::OCC_W'(count_in);
      end
   end

   // One write and one registered read per cycle; a request never does both.
   always_ff @(posedge clock) begin
      if (accept && flags.wr_en) begin
         store_mem[wr_addr] <= req_ch.value;
      end
      if (accept && flags.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = has_read_ff ? rd_data_ff : '0;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.occupancy    = occ_ff;

endmodule

>>> dv/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed and random requests.
module tb_double_ended_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH = deque_pkg::DEPTH_DEFAULT;
   localparam int FUNC_W  = deque_pkg::FUNC_W;
   localparam int VALUE_W = deque_pkg::VALUE_W;
   localparam int POS_W   = deque_pkg::POS_W;
   localparam int DROP_W  = deque_pkg::DROP_W;
   localparam int OCC_W   = deque_pkg::OCC_W;

   // func codes the block decodes as no-ops
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   // one reply as the block should return it
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      deque_pkg::status_type     status;
      logic [OCC_W-1:0]          occupancy;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   deque_req_if req_bus ();
   deque_rsp_if rsp_bus ();

   double_ended_queue u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the queue: ring storage, front slot and element count.
   // Updated in request order, at the edge where each request is accepted.
   // ---------------------------------------------------------------------
   logic [VALUE_W-1:0] slot_data [QDEPTH];
   int                 front_slot = 0;
   int                 held_count = 0;

   queue_reply_type pending_replies [$];   // replies owed by the block, oldest first
   int              mismatch_count = 0;

   // idling control shared by the request and reply sides
   bit idling     = 1'b1;
   int sink_hold  = 0;    // long reply hold-off, counted down by the reply driver
   int sink_stall = 0;

   function automatic int ring_slot(int offset);
      return (front_slot + offset) % QDEPTH;
   endfunction

   // Apply one request to the shadow queue and return the reply it owes.
   function automatic queue_reply_type apply_request(logic [FUNC_W-1:0] func,
                                                     logic [VALUE_W-1:0] val,
                                                     logic [POS_W-1:0] pos,
                                                     logic [DROP_W-1:0] drop);
      queue_reply_type r;
      int              n;
      r.value  = '0;
      r.status = deque_pkg::STATUS_OK;
      case (func)
         deque_pkg::FUNC_PUSH_REAR: begin
            if (held_count >= QDEPTH) begin
               r.status = deque_pkg::STATUS_FULL;
            end else begin
               slot_data[ring_slot(held_count)] = val;
               held_count++;
            end
         end
         deque_pkg::FUNC_POP_FRONT: begin
            if (held_count == 0) begin
               r.status = deque_pkg::STATUS_EMPTY;
            end else begin
               r.value    = slot_data[front_slot];
               front_slot = ring_slot(1);
               held_count--;
            end
         end
         deque_pkg::FUNC_PUSH_FRONT: begin
            if (held_count >= QDEPTH) begin
               r.status = deque_pkg::STATUS_FULL;
            end else begin
               front_slot = ring_slot(QDEPTH - 1);
               slot_data[front_slot] = val;
               held_count++;
            end
         end
         deque_pkg::FUNC_POP_REAR: begin
            if (held_count == 0) begin
               r.status = deque_pkg::STATUS_EMPTY;
            end else begin
               r.value = slot_data[ring_slot(held_count - 1)];
               held_count--;
            end
         end
         deque_pkg::FUNC_PEEK: begin
            // position is 1-based from the front; 0 or past the end is out of range
            if (pos == 0 || int'(pos) > held_count) begin
               r.status = deque_pkg::STATUS_EMPTY;
            end else begin
               r.value = slot_data[ring_slot(int'(pos) - 1)];
            end
         end
         deque_pkg::FUNC_DROP_FRONT: begin
            // saturates at the occupancy
            n          = (int'(drop) < held_count) ? int'(drop) : held_count;
            front_slot = ring_slot(n);
            held_count -= n;
         end
         default: ;   // spare codes: no change
      endcase
      r.occupancy = OCC_W'(held_count);
      return r;
   endfunction

   // gap length: none when not idling, else mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (!idling) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side: drive at the falling edge, take the handshake at the
   // rising edge, and book the expected reply at the edge of acceptance.
   // valid stays high between back-to-back requests.
   // ---------------------------------------------------------------------
   task automatic issue_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] val,
                                logic [POS_W-1:0] pos, logic [DROP_W-1:0] drop);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.func       = func;
      req_bus.value      = val;
      req_bus.position   = pos;
      req_bus.drop_count = drop;
      do @(posedge clock); while (!req_bus.ready);
      pending_replies.push_back(apply_request(func, val, pos, drop));
   endtask

   // sender pause: drop valid and wait for every owed reply
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // weighted random request; keeps the queue away from permanent full/empty
   task automatic random_request();
      int                 r;
      logic [FUNC_W-1:0]  f;
      logic [POS_W-1:0]   p;
      logic [DROP_W-1:0]  d;
      r = $urandom_range(0, 99);
      if (r < 20)      f = deque_pkg::FUNC_PUSH_REAR;
      else if (r < 40) f = deque_pkg::FUNC_PUSH_FRONT;
      else if (r < 53) f = deque_pkg::FUNC_POP_FRONT;
      else if (r < 66) f = deque_pkg::FUNC_POP_REAR;
      else if (r < 88) f = deque_pkg::FUNC_PEEK;
      else if (r < 96) f = deque_pkg::FUNC_DROP_FRONT;
      else             f = (r[0]) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      // near full, turn most pushes into pops but let some be refused
      if ((f == deque_pkg::FUNC_PUSH_REAR || f == deque_pkg::FUNC_PUSH_FRONT)
          && held_count >= QDEPTH - 8 && $urandom_range(0, 3) != 0)
         f = (r[0]) ? deque_pkg::FUNC_POP_FRONT : deque_pkg::FUNC_POP_REAR;

      r = $urandom_range(0, 99);
      if (r < 70 && held_count > 0) p = POS_W'($urandom_range(1, held_count));
      else if (r < 85)              p = (r[0]) ? '0 : POS_W'(held_count + 1);
      else                          p = POS_W'($urandom());

      r = $urandom_range(0, 99);
      if (r < 75)      d = DROP_W'($urandom_range(0, 4));
      else if (r < 92) d = DROP_W'($urandom_range(0, held_count + 2));
      else             d = DROP_W'($urandom());

      issue_request(f, pick_value(), p, d);
   endtask

   // ---------------------------------------------------------------------
   // Reply side: ready driven at the falling edge, with random stalls and
   // an optional long hold-off requested by a test.
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            rsp_bus.ready = 1'b0;
            sink_hold     = sink_hold - 1;
         end else if (sink_stall > 0) begin
            rsp_bus.ready = 1'b0;
            sink_stall    = sink_stall - 1;
         end else begin
            rsp_bus.ready = 1'b1;
            sink_stall    = pick_gap();
         end
      end
   end

   // each accepted reply is checked against the oldest owed one
   always @(posedge clock) begin : check_replies
      queue_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $error("reply with none owed: value %0d status %0d occupancy %0d",
                   rsp_bus.result_value, rsp_bus.status, rsp_bus.occupancy);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.result_value !== want.value) begin
               $error("result_value: expected %0d, got %0d", want.value,
                      rsp_bus.result_value);
               mismatch_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy,
                      rsp_bus.occupancy);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // every read or drop on an empty queue, plus the spare codes
   task automatic test_empty_queue();
      issue_request(deque_pkg::FUNC_POP_FRONT,  '0, '0, '0);
      issue_request(deque_pkg::FUNC_POP_REAR,   '0, '0, '0);
      issue_request(deque_pkg::FUNC_PEEK,       '0, 9'd0, '0);
      issue_request(deque_pkg::FUNC_PEEK,       '0, 9'd1, '0);
      issue_request(deque_pkg::FUNC_DROP_FRONT, '0, '0, 9'd0);
      issue_request(deque_pkg::FUNC_DROP_FRONT, '0, '0, 9'h1ff);
      issue_request(FUNC_SPARE_LO,   32'hffff_ffff, 9'h1ff, 9'h1ff);
      issue_request(FUNC_SPARE_HI,   32'hffff_ffff, 9'h1ff, 9'h1ff);
   endtask

   // each operation with extreme values and range edges
   task automatic test_directed_ops();
      issue_request(deque_pkg::FUNC_PUSH_REAR,  32'h7fff_ffff, '0, '0);
      issue_request(deque_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, '0, '0);
      issue_request(deque_pkg::FUNC_PUSH_REAR,  32'h0000_0000, '0, '0);
      issue_request(deque_pkg::FUNC_PUSH_FRONT, 32'hffff_ffff, '0, '0);
      issue_request(deque_pkg::FUNC_PEEK,       '0, 9'd1, '0);
      issue_request(deque_pkg::FUNC_PEEK,       '0, 9'd4, '0);
      issue_request(deque_pkg::FUNC_PEEK,       '0, 9'd5, '0);     // one past the end
      issue_request(deque_pkg::FUNC_PEEK,       '0, 9'd0, '0);
      issue_request(deque_pkg::FUNC_PEEK,       '0, 9'h1ff, '0);
      issue_request(deque_pkg::FUNC_POP_FRONT,  '0, '0, '0);
      issue_request(deque_pkg::FUNC_POP_REAR,   '0, '0, '0);
      issue_request(deque_pkg::FUNC_DROP_FRONT, '0, '0, 9'd0);     // zero drop
      issue_request(deque_pkg::FUNC_PUSH_REAR,  32'h5555_5555, '0, '0);
      issue_request(deque_pkg::FUNC_DROP_FRONT, '0, '0, 9'd256);   // saturating drop
   endtask

   // fill to capacity, get refused, read at the far end, then empty it
   task automatic test_fill_to_full();
      int i;
      while (held_count < QDEPTH)
         issue_request($urandom_range(0, 1) ? deque_pkg::FUNC_PUSH_REAR
                                            : deque_pkg::FUNC_PUSH_FRONT,
                       pick_value(), '0, '0);
      issue_request(deque_pkg::FUNC_PUSH_REAR,  pick_value(), '0, '0);
      issue_request(deque_pkg::FUNC_PUSH_FRONT, pick_value(), '0, '0);
      issue_request(deque_pkg::FUNC_PEEK, '0, POS_W'(QDEPTH), '0);
      issue_request(deque_pkg::FUNC_PEEK, '0, POS_W'(QDEPTH + 1), '0);
      issue_request(deque_pkg::FUNC_POP_REAR,   '0, '0, '0);
      issue_request(deque_pkg::FUNC_PUSH_FRONT, pick_value(), '0, '0);
      for (i = 0; i < 20; i++)
         issue_request(deque_pkg::FUNC_PEEK, '0, POS_W'($urandom_range(1, QDEPTH)), '0);
      issue_request(deque_pkg::FUNC_DROP_FRONT, '0, '0, DROP_W'(QDEPTH));
   endtask

   // long reply hold-off while requests keep coming, then a sender pause and random requests
   task automatic test_backpressure();
      int i;
      sink_hold = 200;
      for (i = 0; i < 10; i++)
         issue_request(deque_pkg::FUNC_PUSH_REAR, pick_value(), '0, '0);
      wait_drained();
      for (i = 0; i < 10; i++)
         random_request();
   endtask

   // random traffic in segments, some with idling and some without, with a sender pause halfway
   task automatic test_random_mix(int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 100 == 0)
            idling = ($urandom_range(0, 3) != 0);
         if (i == count / 2)
            wait_drained();
         random_request();
      end
      idling = 1'b1;
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.func       = '0;
      req_bus.value      = '0;
      req_bus.position   = '0;
      req_bus.drop_count = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_directed_ops();
      test_fill_to_full();
      test_backpressure();
      test_random_mix(600);

      // all requests in: wait for owed replies before the verdict
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #400_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
